>>> design/mrhp_pkg.sv
`timescale 1ns / 1ps
package mrhp_pkg;

  localparam int MaxRows     = 3;
  localparam int RowNodeBits = 20;
  localparam int RegW        = RowNodeBits + 1;
  localparam int IdxW        = RowNodeBits + 2;
  localparam int KeyW        = 32;
  localparam int ChunkW      = 4;
  localparam int NumStages   = KeyW / ChunkW;

  typedef logic [RegW-1:0] reg_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [2:0] {
    REG_ROWS  = 3'd0,
    REG_MOD0  = 3'd1,
    REG_MOD1  = 3'd2,
    REG_MOD2  = 3'd3,
    REG_CNT0  = 3'd4,
    REG_CNT1  = 3'd5,
    REG_CNT2  = 3'd6
  } reg_idx_t;

  // One restoring division step per key bit of the chunk; the partial remainder
  // stays below a nonzero modulus.
  function automatic reg_t mod_chunk(reg_t rem, logic [ChunkW-1:0] bits, reg_t m);
    logic [RegW:0] r;
    reg_t acc;
    acc = rem;
    for (int i = ChunkW - 1; i >= 0; i--) begin
      r = {acc, bits[i]};
      if (r >= {1'b0, m}) begin
        r = r - {1'b0, m};
      end
      acc = r[RegW-1:0];
    end
    return acc;
  endfunction

endpackage

>>> design/multi_row_hash_probe_index.sv
`timescale 1ns / 1ps
// Multi-row hash probe index generator.
// Key channel: key_valid / key_stall carry short_key and capacity. A request
// is taken at a clock edge with key_valid high and key_stall low.
// Result channel: result_valid / result_stall carry row_number, node_index,
// overflow and last; one result per request for each probed row, ending with
// last, or an overflow result when the capacity runs out first.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; write
// only while no request is in flight.
// A request's first result is shown once it passes the remainder pipeline into
// the output sequencer. The in-row offset is found by an eight-stage remainder
// pipeline, four quotient bits per stage, one lane per row; a request can enter
// every cycle while key_stall is low. The sequencer, which sets the sustained
// rate, gives one result per unstalled cycle until a request's last result.
// Reset (rst, synchronous) empties the pipeline and sets every register to 1.
// When result_stall is high the shown result holds; once the last pipeline
// stage holds a request the sequencer cannot take, the whole pipeline stops
// and key_stall rises.
module multi_row_hash_probe_index
  import mrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        key_valid,
  output logic        key_stall,
  input  logic [31:0] short_key,
  input  logic [1:0]  capacity,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  row_number,
  output idx_t        node_index,
  output logic        overflow,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  reg_t        cfg_data
);

  logic [1:0] rows_in_use;
  reg_t       row_mod [MaxRows];
  reg_t       row_cnt [MaxRows];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 2'd1;
      for (int r = 0; r < MaxRows; r++) begin
        row_mod[r] <= reg_t'(1);
        row_cnt[r] <= reg_t'(1);
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data[1:0];
        REG_MOD0: row_mod[0]  <= cfg_data;
        REG_MOD1: row_mod[1]  <= cfg_data;
        REG_MOD2: row_mod[2]  <= cfg_data;
        REG_CNT0: row_cnt[0]  <= cfg_data;
        REG_CNT1: row_cnt[1]  <= cfg_data;
        REG_CNT2: row_cnt[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Remainder pipeline.
  logic             v    [NumStages];
  logic [KeyW-1:0]  key  [NumStages];
  logic [1:0]       cap  [NumStages];
  reg_t             rem  [NumStages][MaxRows];
  logic             en;
  logic             load_ok;

  assign en        = !v[NumStages-1] || load_ok;
  assign key_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NumStages; s++) begin
        v[s] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= key_valid;
      for (int s = 1; s < NumStages; s++) begin
        v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key[0] <= short_key;
      cap[0] <= capacity;
      for (int r = 0; r < MaxRows; r++) begin
        rem[0][r] <= mod_chunk('0, short_key[KeyW-1 -: ChunkW], row_mod[r]);
      end
      for (int s = 1; s < NumStages; s++) begin
        key[s] <= key[s-1];
        cap[s] <= cap[s-1];
        for (int r = 0; r < MaxRows; r++) begin
          rem[s][r] <= mod_chunk(rem[s-1][r], key[s-1][KeyW-1-s*ChunkW -: ChunkW],
                                 row_mod[r]);
        end
      end
    end
  end

  // Output sequencer.
  logic       busy;
  logic [1:0] cursor;
  logic [1:0] total;
  logic [1:0] nreg;
  logic [1:0] srows;
  idx_t       sidx [MaxRows];

  logic [1:0] rows_eff;
  logic [1:0] m_new;
  logic       ovf_new;
  reg_t       off [MaxRows];
  logic       take;

  assign rows_eff = rows_in_use;
  assign m_new    = (cap[NumStages-1] < rows_eff) ? cap[NumStages-1] : rows_eff;
  assign ovf_new  = cap[NumStages-1] < rows_eff;
  assign take     = busy && !result_stall;
  assign load_ok  = !busy || (take && (cursor + 2'd1 == total));

  always_comb begin
    for (int r = 0; r < MaxRows; r++) begin
      off[r] = (row_mod[r] != '0) ? rem[NumStages-1][r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cursor <= 2'd0;
    end else if (v[NumStages-1] && load_ok) begin
      busy   <= (m_new != 2'd0) || ovf_new;
      cursor <= 2'd0;
    end else if (take) begin
      cursor <= cursor + 2'd1;
      if (cursor + 2'd1 == total) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v[NumStages-1] && load_ok) begin
      total   <= m_new + {1'b0, ovf_new};
      nreg    <= m_new;
      srows   <= rows_eff;
      sidx[0] <= idx_t'(off[0]);
      sidx[1] <= idx_t'(row_cnt[0]) + idx_t'(off[1]);
      sidx[2] <= idx_t'(row_cnt[0]) + idx_t'(row_cnt[1]) + idx_t'(off[2]);
    end
  end

  always_comb begin
    result_valid = busy;
    if (cursor < nreg) begin
      row_number = cursor;
      node_index = sidx[cursor];
      overflow   = 1'b0;
      last       = (cursor + 2'd1 == srows);
    end else begin
      row_number = 2'd0;
      node_index = '0;
      overflow   = 1'b1;
      last       = 1'b1;
    end
  end

endmodule

>>> design/mrhp_checker.sv
`timescale 1ns / 1ps
module mrhp_checker
  import mrhp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [1:0] row_number,
  input idx_t       node_index,
  input logic       overflow,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(node_index)
      && $stable(row_number) && $stable(last))
    else $error("stalled result changed");

  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> last)
    else $error("overflow result without last");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> node_index == '0 && row_number == 2'd0)
    else $error("overflow result carries an index");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> row_number != 2'd3)
    else $error("row number out of range");

endmodule

bind multi_row_hash_probe_index mrhp_checker u_mrhp_checker (
  .clk(clk), .rst(rst), .result_valid(result_valid), .result_stall(result_stall),
  .row_number(row_number), .node_index(node_index), .overflow(overflow), .last(last)
);

>>> verif/multi_row_hash_probe_index_tb.sv
`timescale 1ns / 1ps
module multi_row_hash_probe_index_tb;
  import mrhp_pkg::*;

  typedef struct packed {
    logic [1:0] row;
    idx_t       idx;
    logic       ovf;
    logic       fin;
  } probe_result_t;

  logic        clk;
  logic        rst;
  logic        key_valid;
  logic        key_stall;
  logic [31:0] short_key;
  logic [1:0]  capacity;
  logic        result_valid;
  logic        result_stall;
  logic [1:0]  row_number;
  idx_t        node_index;
  logic        overflow;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  reg_t        cfg_data;

  // Shadow copy of the block's registers.
  logic [1:0] rows_used;
  reg_t       row_mod [3];
  reg_t       row_cnt [3];

  probe_result_t expected_probes[$];
  int errors;
  int results_seen;
  int keys_sent;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;

  multi_row_hash_probe_index u_dut (
    .clk(clk), .rst(rst),
    .key_valid(key_valid), .key_stall(key_stall),
    .short_key(short_key), .capacity(capacity),
    .result_valid(result_valid), .result_stall(result_stall),
    .row_number(row_number), .node_index(node_index),
    .overflow(overflow), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Expected candidates for one key under the current register settings.
  task automatic predict_probes(input logic [31:0] key, input logic [1:0] cap);
    int rows;
    int n;
    logic [63:0] base;
    logic [63:0] off;
    probe_result_t p;
    rows = (rows_used > MaxRows) ? MaxRows : rows_used;
    base = 0;
    n = 0;
    for (int r = 0; r < rows; r++) begin
      if (n >= cap) begin
        p = '{row: 2'd0, idx: '0, ovf: 1'b1, fin: 1'b1};
        expected_probes.push_back(p);
        return;
      end
      off = (row_mod[r] != 0) ? (64'(key) % 64'(row_mod[r])) : 64'd0;
      p.row = 2'(r);
      p.idx = idx_t'(base + off);
      p.ovf = 1'b0;
      p.fin = (r + 1 == rows);
      expected_probes.push_back(p);
      n++;
      base += 64'(row_cnt[r]);
    end
  endtask

  // Result stall: random per phase, plus a counted long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    probe_result_t e;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_probes.size() == 0) begin
        report_mismatch("unexpected result", {8'd0, node_index}, 0);
      end else begin
        e = expected_probes.pop_front();
        if (row_number !== e.row) report_mismatch("row_number", row_number, e.row);
        if (node_index !== e.idx) report_mismatch("node_index", node_index, e.idx);
        if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
        if (last !== e.fin) report_mismatch("last", last, e.fin);
      end
    end
  end

  task automatic send_key(input logic [31:0] key, input logic [1:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    short_key <= key;
    capacity  <= cap;
    predict_probes(key, cap);
    @(posedge clk);
    while (key_stall) @(posedge clk);
    keys_sent++;
  endtask

  task automatic drain();
    key_valid <= 1'b0;
    @(posedge clk);
    while (expected_probes.size() != 0) @(posedge clk);
    // A key with no rows gives no result but may still be in the pipeline.
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input reg_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROWS: rows_used  = value[1:0];
      REG_MOD0: row_mod[0] = value;
      REG_MOD1: row_mod[1] = value;
      REG_MOD2: row_mod[2] = value;
      REG_CNT0: row_cnt[0] = value;
      REG_CNT1: row_cnt[1] = value;
      REG_CNT2: row_cnt[2] = value;
      default: ;
    endcase
  endtask

  task automatic set_table(input logic [1:0] rows, input reg_t m0, input reg_t m1,
                           input reg_t m2, input reg_t c0, input reg_t c1,
                           input reg_t c2);
    write_reg(REG_ROWS, reg_t'(rows));
    write_reg(REG_MOD0, m0);
    write_reg(REG_MOD1, m1);
    write_reg(REG_MOD2, m2);
    write_reg(REG_CNT0, c0);
    write_reg(REG_CNT1, c1);
    write_reg(REG_CNT2, c2);
  endtask

  task automatic test_reset_table();
    send_key(32'hFFFF_FFFF, 2'd3);
    send_key(32'h0, 2'd0);
    drain();
  endtask

  task automatic test_field_extremes();
    set_table(2'd3, 21'd1048576, 21'd7, 21'd1000, 21'd1048576, 21'd1048576, 21'd5);
    send_key(32'h0, 2'd3);
    send_key(32'hFFFF_FFFF, 2'd3);
    send_key(32'h8000_0000, 2'd3);
    send_key(32'h5555_5555, 2'd3);
    send_key(32'hAAAA_AAAA, 2'd3);
    drain();
  endtask

  task automatic test_capacity_overflow();
    for (int c = 0; c < 4; c++) send_key($urandom, 2'(c));
    drain();
  endtask

  task automatic test_register_corners();
    // Zero modulus, zero rows, and a node index sum near the top of the index range.
    set_table(2'd3, 21'd0, 21'h1F_FFFF, 21'd0, 21'h1F_FFFF, 21'h1F_FFFF, 21'd1);
    send_key(32'hFFFF_FFFF, 2'd3);
    send_key(32'h1234_5678, 2'd2);
    drain();
    write_reg(REG_ROWS, '0);
    send_key(32'hDEAD_BEEF, 2'd3);
    send_key(32'h0, 2'd0);
    drain();
    write_reg(REG_ROWS, 21'd2);
    send_key(32'h0BAD_F00D, 2'd1);
    send_key(32'h0BAD_F00D, 2'd2);
    drain();
  endtask

  task automatic random_table();
    reg_t v[6];
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(3))
        0: v[i] = reg_t'($urandom_range(1, 16));
        1: v[i] = 21'd1048576;
        default: v[i] = reg_t'($urandom_range(1, 1048576));
      endcase
    end
    set_table(2'($urandom_range(1, 3)), v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic test_random_traffic(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    random_table();
    for (int i = 0; i < n; i++) begin
      send_key($urandom, 2'($urandom_range(3)));
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_table(2'd3, 21'd97, 21'd1031, 21'd65521, 21'd200, 21'd3000, 21'd9);
    hold_cycles = 200;
    for (int i = 0; i < 20; i++) send_key($urandom, 2'd3);
    // The sender stops until the whole backlog has drained.
    drain();
  endtask

  initial begin
    rst = 1'b1;
    key_valid = 1'b0;
    short_key = '0;
    capacity = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    results_seen = 0;
    keys_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rows_used = 2'd1;
    for (int r = 0; r < 3; r++) begin
      row_mod[r] = 21'd1;
      row_cnt[r] = 21'd1;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_table();
    test_field_extremes();
    test_capacity_overflow();
    test_register_corners();
    test_backpressure();
    test_random_traffic(35, 0, 0);
    test_random_traffic(35, 50, 0);
    test_random_traffic(35, 0, 50);
    test_random_traffic(35, 11, 11);

    $display("Sent %0d keys over varied row tables, capacities and stall patterns;",
             keys_sent);
    $display("checked %0d probe results, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mrhp_pkg.sv
design/multi_row_hash_probe_index.sv
design/mrhp_checker.sv
verif/multi_row_hash_probe_index_tb.sv
